>>> rtl/trilinear_volume_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Trilinear volume sampler assertion macros
// Shared concurrent assertion forms for the sampler checker.
// ----------------------------------------------------------------------------
`ifndef TRILINEAR_VOLUME_SAMPLER_UNIT_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TVS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvs assertion failed");

// next-cycle implication, disabled while reset is asserted
`define TVS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvs assertion failed");

`endif

>>> rtl/tvs_pkg.sv
// ----------------------------------------------------------------------------
// Trilinear volume sampler package
// Field widths, bus layout, codes and defaults shared by the sampler files.
// ----------------------------------------------------------------------------
package tvs_pkg;

    // payload field widths
    localparam int COORD_W       = 16;
    localparam int CFG_SIZE_W    = 7;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int VOXEL_ADDR_W  = 18;
    localparam int VOXEL_VALUE_W = 16;
    localparam int SAMPLE_W      = 16;

    // slave tdata layout, lowest bit first
    localparam int IN_ADDR_LSB   = 0;
    localparam int IN_VALUE_LSB  = IN_ADDR_LSB + VOXEL_ADDR_W;
    localparam int IN_CX_LSB     = IN_VALUE_LSB + VOXEL_VALUE_W;
    localparam int IN_CY_LSB     = IN_CX_LSB + COORD_W;
    localparam int IN_CZ_LSB     = IN_CY_LSB + COORD_W;
    localparam int IN_USED_W     = IN_CZ_LSB + COORD_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = SAMPLE_W;

    // parameter defaults
    localparam int DEF_MAX_SIZE_X  = 64;
    localparam int DEF_MAX_SIZE_Y  = 64;
    localparam int DEF_MAX_SIZE_Z  = 64;
    localparam int DEF_VALUE_BITS  = 16;
    localparam int DEF_FRAC_BITS   = 8;

    // register reset values
    localparam logic [CFG_SIZE_W-1:0] RST_SIZE    = CFG_SIZE_W'(64);
    localparam logic [CFG_DATA_W-1:0] RST_OUTSIDE = '0;

    // command codes carried in tuser
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SIZE_X,
        CFG_SIZE_Y,
        CFG_SIZE_Z,
        CFG_OUTSIDE
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_BASE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

endpackage

>>> rtl/trilinear_volume_sampler_unit.sv
// A voxel write gives no result; a sample that falls outside goes straight to S_DONE and
// the output register, while an inside sample first passes S_MUL0, S_MUL1, S_BASE, S_RUN
// and S_DRAIN. Samples do not overlap: a new command waits out the eight corner reads
// through the single-port volume RAM, three index states and a four-stage blend pipeline.
// Reset (synchronous, active low) restores sizes 64/64/64 and outside value 0 and empties
// the control path; volume RAM contents stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// Trilinear volume sampler
// Stores a signed 3-D volume x-fastest and answers trilinear samples at
// one-based fixed-point grid coordinates, rounded half up.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler_unit #(
    parameter int MAX_SIZE_X = tvs_pkg::DEF_MAX_SIZE_X,
    parameter int MAX_SIZE_Y = tvs_pkg::DEF_MAX_SIZE_Y,
    parameter int MAX_SIZE_Z = tvs_pkg::DEF_MAX_SIZE_Z,
    parameter int VALUE_BITS = tvs_pkg::DEF_VALUE_BITS,
    parameter int FRAC_BITS  = tvs_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [tvs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tvs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // command stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // voxel_address[17:0], voxel_value, coord_x, coord_y, coord_z, zero pad
    input  logic [tvs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // command
    input  logic                                s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // sample_value
    output logic [tvs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // outside
    output logic                                m_axis_tuser
);

    import tvs_pkg::*;

    // geometry
    localparam int DEPTH  = MAX_SIZE_X * MAX_SIZE_Y * MAX_SIZE_Z;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SX_W   = $clog2(MAX_SIZE_X + 1);
    localparam int SY_W   = $clog2(MAX_SIZE_Y + 1);
    localparam int SZ_W   = $clog2(MAX_SIZE_Z + 1);
    localparam int IX_W   = $clog2(MAX_SIZE_X);
    localparam int IY_W   = $clog2(MAX_SIZE_Y);
    localparam int IZ_W   = $clog2(MAX_SIZE_Z);
    localparam int XY_W   = $clog2(MAX_SIZE_X * MAX_SIZE_Y + 1);

    // blend arithmetic
    localparam int ONE    = 1 << FRAC_BITS;
    localparam int W1     = FRAC_BITS + 1;              // one axis weight, 0..ONE
    localparam int ACC_W  = VALUE_BITS + 3 * W1 + 1;    // signed corner * weight
    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (3 * FRAC_BITS - 1));

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_SIZE_W-1:0] r_size_x, r_size_y, r_size_z;
    logic [CFG_DATA_W-1:0] r_outside_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x      <= RST_SIZE;
            r_size_y      <= RST_SIZE;
            r_size_z      <= RST_SIZE;
            r_outside_val <= RST_OUTSIDE;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_X:  r_size_x      <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_SIZE_Y:  r_size_y      <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_SIZE_Z:  r_size_z      <= i_cfg_data[CFG_SIZE_W-1:0];
                CFG_OUTSIDE: r_outside_val <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sizes in use saturate at the volume maxima
    logic [SX_W-1:0] sx_use;
    logic [SY_W-1:0] sy_use;
    logic [SZ_W-1:0] sz_use;

    assign sx_use = (32'(r_size_x) > 32'(MAX_SIZE_X)) ? SX_W'(MAX_SIZE_X) : SX_W'(r_size_x);
    assign sy_use = (32'(r_size_y) > 32'(MAX_SIZE_Y)) ? SY_W'(MAX_SIZE_Y) : SY_W'(r_size_y);
    assign sz_use = (32'(r_size_z) > 32'(MAX_SIZE_Z)) ? SZ_W'(MAX_SIZE_Z) : SZ_W'(r_size_z);

    // ------------------------------------------------------------------
    // input decode and region test
    // ------------------------------------------------------------------
    logic                        in_cmd;
    logic [VOXEL_ADDR_W-1:0]     in_addr;
    logic signed [COORD_W-1:0]   in_cx, in_cy, in_cz;
    logic signed [VOXEL_VALUE_W-1:0] in_value;

    assign in_cmd   = s_axis_tuser;
    assign in_addr  = s_axis_tdata[IN_ADDR_LSB +: VOXEL_ADDR_W];
    assign in_value = $signed(s_axis_tdata[IN_VALUE_LSB +: VOXEL_VALUE_W]);
    assign in_cx    = $signed(s_axis_tdata[IN_CX_LSB +: COORD_W]);
    assign in_cy    = $signed(s_axis_tdata[IN_CY_LSB +: COORD_W]);
    assign in_cz    = $signed(s_axis_tdata[IN_CZ_LSB +: COORD_W]);

    // zero-based fixed-point position; valid when coord >= 1 and upper corner < size
    int  pos_x, pos_y, pos_z;
    logic ok_x, ok_y, ok_z;

    always_comb begin
        pos_x = int'(in_cx) - ONE;
        pos_y = int'(in_cy) - ONE;
        pos_z = int'(in_cz) - ONE;
        ok_x  = (pos_x >= 0) && ((pos_x >>> FRAC_BITS) + 1 < int'(sx_use));
        ok_y  = (pos_y >= 0) && ((pos_y >>> FRAC_BITS) + 1 < int'(sy_use));
        ok_z  = (pos_z >= 0) && ((pos_z >>> FRAC_BITS) + 1 < int'(sz_use));
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   in_acc, wr_acc, smp_acc;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign wr_acc  = in_acc && (in_cmd == CMD_WRITE);
    assign smp_acc = in_acc && (in_cmd == CMD_SAMPLE);

    // per-sample registers
    logic [IX_W-1:0]      r_i;
    logic [IY_W-1:0]      r_j;
    logic [IZ_W-1:0]      r_k;
    logic [FRAC_BITS-1:0] r_dx, r_dy, r_dz;
    logic                 r_outside;
    logic [XY_W-1:0]      r_sxy;
    logic [ADDR_W-1:0]    r_yoff, r_zoff, r_base;
    logic [2:0]           r_cnt;

    // blend pipeline
    logic                         r_v1, r_v2, r_v3;
    logic                         r_z1;
    logic [2*W1-1:0]              r_wxy;
    logic [3*W1-1:0]              r_w;
    logic signed [VALUE_BITS-1:0] r_c;
    logic signed [ACC_W-1:0]      r_prod, r_acc;

    // output register
    logic                   r_m_valid;
    logic [SAMPLE_W-1:0]    r_m_data;
    logic                   r_m_user;

    logic out_load;
    logic drained;

    assign drained  = !r_v1 && !r_v2 && !r_v3;
    assign out_load = (r_state == S_DONE) && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (smp_acc) begin
                    n_state = (ok_x && ok_y && ok_z) ? S_MUL0 : S_DONE;
                end
            end
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_BASE;
            S_BASE:  n_state = S_RUN;
            S_RUN: begin
                if (r_cnt == 3'd7) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drained) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // volume memory
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0]     corner_off, corner_addr, ram_addr;
    logic                  ram_we;
    logic [VALUE_BITS-1:0] ram_rdata;

    // corner bit0 steps x, bit1 steps a row, bit2 steps a plane
    assign corner_off  = ADDR_W'(r_cnt[0])
                       + (r_cnt[1] ? ADDR_W'(sx_use) : '0)
                       + (r_cnt[2] ? ADDR_W'(r_sxy)  : '0);
    assign corner_addr = r_base + corner_off;
    assign ram_addr    = (r_state == S_IDLE) ? ADDR_W'(in_addr) : corner_addr;
    // writes past the store are dropped
    assign ram_we      = wr_acc && (32'(in_addr) < 32'(DEPTH));

    tvs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (VALUE_BITS'(in_value)),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // sample capture and address generation
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_i       <= IX_W'(pos_x >>> FRAC_BITS);
            r_j       <= IY_W'(pos_y >>> FRAC_BITS);
            r_k       <= IZ_W'(pos_z >>> FRAC_BITS);
            r_dx      <= FRAC_BITS'(pos_x);
            r_dy      <= FRAC_BITS'(pos_y);
            r_dz      <= FRAC_BITS'(pos_z);
            r_outside <= !(ok_x && ok_y && ok_z);
        end
        if (r_state == S_MUL0) begin
            r_sxy  <= XY_W'(sx_use * sy_use);
            r_yoff <= ADDR_W'(sx_use * r_j);
        end
        if (r_state == S_MUL1) begin
            r_zoff <= ADDR_W'(r_sxy * r_k);
        end
        if (r_state == S_BASE) begin
            r_base <= ADDR_W'(r_i) + r_yoff + r_zoff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state == S_RUN) begin
            r_cnt <= r_cnt + 3'd1;
        end else begin
            r_cnt <= '0;
        end
    end

    // ------------------------------------------------------------------
    // blend pipeline: weight xy, weight xyz with RAM data, product, accumulate
    // ------------------------------------------------------------------
    logic [W1-1:0] wx, wy, wz;

    assign wx = r_cnt[0] ? W1'(r_dx) : W1'(ONE) - W1'(r_dx);
    assign wy = r_cnt[1] ? W1'(r_dy) : W1'(ONE) - W1'(r_dy);
    assign wz = r_z1     ? W1'(r_dz) : W1'(ONE) - W1'(r_dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_RUN);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wxy  <= wx * wy;
        r_z1   <= r_cnt[2];
        r_w    <= r_wxy * wz;
        r_c    <= $signed(ram_rdata);
        r_prod <= ACC_W'(r_c * $signed({1'b0, r_w}));
        if (r_state == S_BASE) begin
            r_acc <= '0;
        end else if (r_v3) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // round half up: add half an LSB of scale 2^3F, then floor
    logic signed [ACC_W-1:0]  rnd_sum;
    logic [VALUE_BITS-1:0]    rnd_bits;

    assign rnd_sum  = r_acc + $signed(RND_HALF);
    assign rnd_bits = rnd_sum[3*FRAC_BITS +: VALUE_BITS];

    // ------------------------------------------------------------------
    // output register: a finished result waits here without blocking input
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= r_outside ? r_outside_val : SAMPLE_W'(rnd_bits);
            r_m_user <= r_outside;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

>>> rtl/tvs_ram.sv
// ----------------------------------------------------------------------------
// Trilinear volume sampler RAM
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tvs_checker.sv
// ----------------------------------------------------------------------------
// Trilinear volume sampler checker
// Port-level assertions on the sampler streams, bound to the top level.
// ----------------------------------------------------------------------------
`include "trilinear_volume_sampler_unit_macros.svh"

module tvs_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [tvs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tuser
);

    import tvs_pkg::*;

    // a stalled result stays offered
    `TVS_ASSERT_NXT(a_m_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a stalled result keeps its payload
    `TVS_ASSERT_NXT(a_m_stable, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // a sample transaction occupies the block for at least the next cycle
    `TVS_ASSERT_NXT(a_smp_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_SAMPLE), !s_axis_tready)

    // a voxel write leaves the block ready in the next cycle
    `TVS_ASSERT_NXT(a_wr_free, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE), s_axis_tready)

endmodule

bind trilinear_volume_sampler_unit tvs_checker u_tvs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
